[sv/kpd_pkg.sv]
// Shared types, operation codes and the key code table of the keypad scanner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package kpd_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;
  localparam int unsigned QCOUNT_W       = 7;
  localparam int unsigned KEY_W          = 8;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned INTERVAL_W     = 16;

  localparam logic [INTERVAL_W-1:0] REPEAT_RESET = 16'd500;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SCAN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] code;
  } key_map_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [KEY_W-1:0] data;
  } fifo_req_t;

  // Raw position code (row in the high nibble, column in the low nibble) to key code.
  function automatic key_map_t map_key(input logic [7:0] raw);
    key_map_t m;
    m.hit = 1'b1;
    unique case (raw)
      8'h10:   m.code = 8'h2E;
      8'h00:   m.code = 8'h30;
      8'h03:   m.code = 8'h31;
      8'h13:   m.code = 8'h32;
      8'h23:   m.code = 8'h33;
      8'h02:   m.code = 8'h34;
      8'h12:   m.code = 8'h35;
      8'h22:   m.code = 8'h36;
      8'h01:   m.code = 8'h37;
      8'h11:   m.code = 8'h38;
      8'h21:   m.code = 8'h39;
      8'h33:   m.code = 8'h41;
      8'h43:   m.code = 8'h42;
      8'h32:   m.code = 8'h43;
      8'h42:   m.code = 8'h44;
      8'h31:   m.code = 8'h45;
      8'h41:   m.code = 8'h46;
      8'h53:   m.code = 8'h26;
      8'h52:   m.code = 8'h28;
      8'h50:   m.code = 8'h25;
      8'h51:   m.code = 8'h27;
      8'h73:   m.code = 8'h08;
      8'h72:   m.code = 8'h0D;
      8'h71:   m.code = 8'h1B;
      8'h20:   m.code = 8'h70;
      8'h30:   m.code = 8'h71;
      8'h40:   m.code = 8'h72;
      8'h62:   m.code = 8'h12;
      8'h63:   m.code = 8'h80;
      default: begin
        m.hit  = 1'b0;
        m.code = '0;
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/kpd_decode.sv]
// Finds the first pressed key of an active-low 8x8 snapshot and maps it to a key code.
// Depends on kpd_pkg for the key table.
`default_nettype none

module kpd_decode (
  input  wire logic [63:0]     key_matrix_i,
  output kpd_pkg::key_map_t    key_o
);
  import kpd_pkg::*;

  logic [7:0] row_hit;
  logic [2:0] row_sel;
  logic [7:0] row_bits;
  logic [2:0] col_sel;
  logic       any_hit;

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      row_hit[r] = ~&key_matrix_i[r*8 +: 8];
    end
  end

  // Lowest pressed row wins, then the lowest pressed column in it.
  always_comb begin
    row_sel = '0;
    for (int r = 7; r >= 0; r--) begin
      if (row_hit[r]) begin
        row_sel = 3'(r);
      end
    end
  end

  assign row_bits = key_matrix_i[row_sel*8 +: 8];

  always_comb begin
    col_sel = '0;
    for (int c = 7; c >= 0; c--) begin
      if (!row_bits[c]) begin
        col_sel = 3'(c);
      end
    end
  end

  assign any_hit = |row_hit;

  key_map_t mapped;
  assign mapped = map_key({1'b0, row_sel, 1'b0, col_sel});

  assign key_o.hit  = any_hit & mapped.hit;
  assign key_o.code = mapped.code;

endmodule

`default_nettype wire

[sv/kpd_fifo.sv]
// Key queue: a synchronous memory with head and tail pointers and a fill count.
// Depends on kpd_pkg for the request struct.
`default_nettype none

module kpd_fifo #(
  parameter int unsigned FIFO_DEPTH = kpd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  kpd_pkg::fifo_req_t                       req_i,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]          count_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]          count_next_o,
  output logic [kpd_pkg::KEY_W-1:0]                rd_data_o
);
  import kpd_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH+1);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  logic [KEY_W-1:0] mem_q [FIFO_DEPTH];
  logic [KEY_W-1:0] rd_data_q;
  logic [AW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;

  // A push and a pop never come in the same request, so the count moves by one at most.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d  = (tail_q == LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (req_i.pop) begin
      head_d  = (head_q == LAST) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[tail_q] <= req_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign count_o      = count_q;
  assign count_next_o = count_d;
  assign rd_data_o    = rd_data_q;

endmodule

`default_nettype wire

[sv/matrix_keypad_scan_repeat_fifo_top.sv]
// Top level of the 8x8 keypad scanner with key repeat and a key queue.
// Depends on kpd_pkg, kpd_decode and kpd_fifo.
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------------------
// input     | in        | in_valid_i / in_ready_o   | opcode_i, key_matrix_i
// result    | out       | out_valid_o / out_ready_i | read_data_o, read_valid_o, key_pushed_o,
//           |           |                           | queue_count_o
// config    | in        | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One request is accepted per cycle while in_ready_o is high; it is registered in the decode stage
// and then in the result register, from which its result is presented until out_ready_i takes it.
// The first stage decodes the key snapshot; the second updates the time, repeat and queue
// state and reads or writes the queue memory, whose registered read data feeds the result.
// Reset clears the control state, the time and the last key; the queue memory needs no
// clearing pass. A stalled result holds only the result register; requests are still taken
// while the decode stage is empty.

module matrix_keypad_scan_repeat_fifo_top #(
  parameter int unsigned FIFO_DEPTH = kpd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [63:0] key_matrix_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             read_valid_o,
  output logic             key_pushed_o,
  output logic [6:0]       queue_count_o,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import kpd_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH+1);

  // Configuration registers. Register index sits at paddr bit 2 (byte address 4*i).
  logic                  enable_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      interval_q <= REPEAT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ENABLE) begin
        enable_q <= pwdata[0];
      end else begin
        interval_q <= pwdata[INTERVAL_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_INTERVAL) ? {16'b0, interval_q} : {31'b0, enable_q};

  // Pipeline handshake. Each stage loads when it is empty or is moving on.
  logic s1_v_q, out_v_q;
  logic out_free, s1_adv, in_acc;

  assign out_free   = !out_v_q || out_ready_i;
  assign s1_adv     = s1_v_q && out_free;
  assign in_ready_o = !s1_v_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Stage one: decode the snapshot into a key code.
  key_map_t         dec_key;
  logic [1:0]       s1_op_q;
  key_map_t         s1_key_q;

  kpd_decode u_decode (
    .key_matrix_i (key_matrix_i),
    .key_o        (dec_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= opcode_i;
      s1_key_q <= dec_key;
    end
  end

  // Stage two: time, repeat filter and queue update, all at the edge that moves the
  // request into the result register.
  logic [TIME_W-1:0] time_q, time_d;
  logic [KEY_W-1:0]  last_key_q, last_key_d;
  logic [TIME_W-1:0] last_push_q, last_push_d;
  logic [TIME_W-1:0] elapsed;
  logic              scan_hit, same_key, key_take;
  logic              rvalid_d;
  fifo_req_t         fifo_req;
  logic [CW-1:0]     count, count_next;
  logic [KEY_W-1:0]  fifo_rd_data;

  assign elapsed  = time_q - last_push_q;
  assign scan_hit = s1_adv && (s1_op_q == OP_SCAN) && enable_q && s1_key_q.hit;
  assign same_key = (s1_key_q.code == last_key_q);
  // A new key always goes through; a held key only once the repeat interval has passed.
  assign key_take = scan_hit && (!same_key || (elapsed >= {16'b0, interval_q}));

  always_comb begin
    time_d        = time_q;
    last_key_d    = last_key_q;
    last_push_d   = last_push_q;
    rvalid_d      = 1'b0;
    fifo_req.push = 1'b0;
    fifo_req.pop  = 1'b0;
    fifo_req.data = s1_key_q.code;
    if (s1_adv && (s1_op_q == OP_TICK)) begin
      time_d = time_q + 1'b1;
    end
    if (scan_hit && !same_key) begin
      last_key_d = s1_key_q.code;
    end
    if (key_take) begin
      last_push_d   = time_q;
      // A key taken while the queue is full still counts as pushed; the byte is lost.
      fifo_req.push = (count != CW'(FIFO_DEPTH));
    end
    if (s1_adv && (s1_op_q == OP_READ) && (count != '0)) begin
      fifo_req.pop = 1'b1;
      rvalid_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      last_key_q  <= '0;
      last_push_q <= '0;
    end else begin
      time_q      <= time_d;
      last_key_q  <= last_key_d;
      last_push_q <= last_push_d;
    end
  end

  kpd_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (fifo_req),
    .count_o      (count),
    .count_next_o (count_next),
    .rd_data_o    (fifo_rd_data)
  );

  // Result register. The popped byte comes straight from the memory's read register,
  // which only changes when the next pop moves a request into this register.
  logic                rvalid_q, pushed_q;
  logic [QCOUNT_W-1:0] qcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rvalid_q <= rvalid_d;
      pushed_q <= key_take;
      qcount_q <= QCOUNT_W'(count_next);
    end
  end

  assign out_valid_o   = out_v_q;
  assign read_valid_o  = rvalid_q;
  assign read_data_o   = rvalid_q ? fifo_rd_data : '0;
  assign key_pushed_o  = pushed_q;
  assign queue_count_o = qcount_q;

endmodule

`default_nettype wire
